// ----- src/divider_and_reloading_timer_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the divider and reloading timer core
// Shared concurrent-assertion wrappers, clocked on clk_i and reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef DIVIDER_AND_RELOADING_TIMER_CORE_ASSERT_SVH
`define DIVIDER_AND_RELOADING_TIMER_CORE_ASSERT_SVH

// Property checked at every edge outside reset.
`define DART_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication outside reset.
`define DART_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication outside reset.
`define DART_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/dart_pkg.sv -----
// ----------------------------------------------------------------------------
// dart_pkg
// Types, constants and the period table of the divider and reloading timer.
// ----------------------------------------------------------------------------
package dart_pkg;

  localparam int unsigned CyclesW = 7;
  localparam int unsigned PeriodW = 11;

  // Divider countdown reload, held in 1..256.
  localparam logic [8:0] DivReload = 9'd256;

  typedef enum logic [1:0] {
    REG_TIMER_ENABLE = 2'd0,
    REG_CLOCK_SELECT = 2'd1,
    REG_TIMER_MODULO = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic       enable;
    logic [1:0] select;
    logic [7:0] modulo;
  } cfg_t;

  typedef struct packed {
    logic [7:0] value;
    logic       irq;
  } tmr_res_t;

  function automatic logic [PeriodW-1:0] period_of(input logic [1:0] sel);
    logic [PeriodW-1:0] p;
    case (sel)
      2'd0:    p = 11'd1024;
      2'd1:    p = 11'd16;
      2'd2:    p = 11'd64;
      default: p = 11'd256;
    endcase
    return p;
  endfunction

endpackage

// ----- src/dart_if.sv -----
// ----------------------------------------------------------------------------
// dart_in_if / dart_out_if
// Valid/ready channels carrying the step input word and the result word.
// ----------------------------------------------------------------------------
interface dart_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] elapsed_cycles;

  modport source (output valid, output elapsed_cycles, input ready);
  modport sink   (input valid, input elapsed_cycles, output ready);
endinterface

interface dart_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] divider_value;
  logic [7:0] timer_value;
  logic       timer_interrupt;

  modport source (output valid, output divider_value, output timer_value,
                  output timer_interrupt, input ready);
  modport sink   (input valid, input divider_value, input timer_value,
                  input timer_interrupt, output ready);
endinterface

// ----- src/divider_and_reloading_timer_core.sv -----
// ----------------------------------------------------------------------------
// divider_and_reloading_timer_core
// Divider and reloading timer stepped by elapsed-cycle words.
// The result word of each accepted input word is held in the output register.
// Throughput: 1 word per cycle unless out_ch stalls; state updates at accept.
// The result register frees in the cycle it is taken, so input and output
// stream back to back. Reset clears config, state and output valid at once.
// ----------------------------------------------------------------------------
module divider_and_reloading_timer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  dart_in_if.sink    in_ch,
  dart_out_if.source out_ch
);
  import dart_pkg::*;

  cfg_t     cfg_q;
  tmr_res_t tmr_res;
  logic [7:0] div_value;

  logic       in_fire;
  logic       out_fire;
  logic       out_valid_q, out_valid_d;
  logic [7:0] div_value_q;
  logic [7:0] timer_value_q;
  logic       irq_q;

  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_q && out_ch.ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_TIMER_ENABLE: cfg_q.enable <= cfg_wdata_i[0];
        REG_CLOCK_SELECT: cfg_q.select <= cfg_wdata_i[1:0];
        REG_TIMER_MODULO: cfg_q.modulo <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  dart_div_unit u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_fire),
    .cycles_i    (in_ch.elapsed_cycles),
    .div_value_o (div_value)
  );

  dart_tmr_unit u_tmr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (in_fire),
    .cycles_i (in_ch.elapsed_cycles),
    .cfg_i    (cfg_q),
    .res_o    (tmr_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      div_value_q   <= div_value;
      timer_value_q <= tmr_res.value;
      irq_q         <= tmr_res.irq;
    end
  end

  assign out_ch.valid           = out_valid_q;
  assign out_ch.divider_value   = div_value_q;
  assign out_ch.timer_value     = timer_value_q;
  assign out_ch.timer_interrupt = irq_q;

`include "divider_and_reloading_timer_core_assert.svh"
  `DART_ASSERT_NXT(a_fire_valid, in_fire, out_valid_q, "accepted word gave no result")
  `DART_ASSERT_NXT(a_drain, out_fire && !in_fire, !out_valid_q, "result repeated")
  `DART_ASSERT_IMP(a_empty_ready, !out_valid_q, in_ch.ready, "empty core refused input")

endmodule

// ----- src/dart_div_unit.sv -----
// ----------------------------------------------------------------------------
// dart_div_unit
// Free-running divider: countdown by elapsed cycles, bump the 8-bit value.
// ----------------------------------------------------------------------------
module dart_div_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [dart_pkg::CyclesW-1:0] cycles_i,
  output logic [7:0]                  div_value_o
);
  import dart_pkg::*;

  logic [8:0]        cnt_q, cnt_d;
  logic [7:0]        div_q, div_d;
  logic signed [9:0] diff;
  logic signed [9:0] wrapped;
  logic              wrap;

  assign diff    = signed'({1'b0, cnt_q}) - signed'({3'b000, cycles_i});
  assign wrap    = (diff <= 10'sd0);
  assign wrapped = diff + signed'({1'b0, DivReload});

  always_comb begin
    cnt_d = cnt_q;
    div_d = div_q;
    if (step_i) begin
      cnt_d = wrap ? wrapped[8:0] : diff[8:0];
      div_d = wrap ? div_q + 8'd1 : div_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= DivReload;
      div_q <= 8'd0;
    end else begin
      cnt_q <= cnt_d;
      div_q <= div_d;
    end
  end

  // Result of this step, seen by the output register.
  assign div_value_o = div_d;

`include "divider_and_reloading_timer_core_assert.svh"
  `DART_ASSERT(a_cnt_range, (cnt_q != 9'd0) && (cnt_q <= DivReload), "divider countdown range")
  `DART_ASSERT_NXT(a_zero_hold, step_i && (cycles_i == '0), $stable(div_q),
    "divider moved on zero cycles")
  `DART_ASSERT_NXT(a_idle_hold, !step_i, $stable(cnt_q) && $stable(div_q),
    "divider moved without a step")

endmodule

// ----- src/dart_tmr_unit.sv -----
// ----------------------------------------------------------------------------
// dart_tmr_unit
// Reloading timer: select tracking, saturating tick countdown, modulo reload.
// ----------------------------------------------------------------------------
module dart_tmr_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [dart_pkg::CyclesW-1:0] cycles_i,
  input  dart_pkg::cfg_t              cfg_i,
  output dart_pkg::tmr_res_t          res_o
);
  import dart_pkg::*;

  localparam logic signed [16:0] TickFloor = -17'sd32768;
  localparam logic signed [16:0] TickCeil  = 17'sd32767;
  localparam logic signed [16:0] StepLimit = -17'sd4;

  logic signed [15:0] tick_q, tick_d;
  logic [7:0]         cnt_q, cnt_d;
  logic [1:0]         sel_q, sel_d;
  logic               irq;

  logic signed [16:0] diff;
  logic signed [16:0] sat;
  logic signed [16:0] bumped;
  logic signed [16:0] after;
  logic               tick;

  assign diff   = signed'({tick_q[15], tick_q}) - signed'({10'd0, cycles_i});
  assign sat    = (diff < TickFloor) ? TickFloor : diff;
  assign tick   = (sat <= StepLimit);
  assign bumped = sat + signed'({6'd0, period_of(sel_q)});
  assign after  = tick ? ((bumped > TickCeil) ? TickCeil : bumped) : sat;

  always_comb begin
    tick_d = tick_q;
    cnt_d  = cnt_q;
    sel_d  = sel_q;
    irq    = 1'b0;
    if (step_i && cfg_i.enable) begin
      if (sel_q == cfg_i.select) begin
        tick_d = after[15:0];
        if (tick) begin
          if (cnt_q == 8'hff) begin
            cnt_d = cfg_i.modulo;
            irq   = 1'b1;
          end else begin
            cnt_d = cnt_q + 8'd1;
          end
        end
      end else begin
        // New select: restart the timer on the new period.
        sel_d  = cfg_i.select;
        cnt_d  = 8'd0;
        tick_d = signed'({5'd0, period_of(cfg_i.select)});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= 16'sd0;
      cnt_q  <= 8'd0;
      sel_q  <= 2'd0;
    end else begin
      tick_q <= tick_d;
      cnt_q  <= cnt_d;
      sel_q  <= sel_d;
    end
  end

  assign res_o.value = cnt_d;
  assign res_o.irq   = irq;

`include "divider_and_reloading_timer_core_assert.svh"
  `DART_ASSERT_NXT(a_off_hold, step_i && !cfg_i.enable,
    $stable(tick_q) && $stable(cnt_q) && $stable(sel_q), "timer moved while disabled")
  `DART_ASSERT_NXT(a_idle_hold, !step_i,
    $stable(tick_q) && $stable(cnt_q) && $stable(sel_q), "timer moved without a step")
  `DART_ASSERT_IMP(a_irq_reload, irq, (cnt_q == 8'hff) && (cnt_d == cfg_i.modulo),
    "interrupt without overflow reload")

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the divider and reloading timer core. A clocked
// driver streams elapsed-cycle words from a queue while the receiver stalls at
// random; a monitor predicts divider, timer and interrupt for every accepted
// word and checks each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dart_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned LongHoldCycles = 300;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] divider;
    logic [7:0] timer;
    logic       intr;
  } step_res_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [7:0] cfg_wdata;

  dart_in_if  in_ch ();
  dart_out_if out_ch ();

  divider_and_reloading_timer_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // Predicted register copy and timer state
  logic       cfg_en;
  logic [1:0] cfg_sel;
  logic [7:0] cfg_mod;
  int         div_left;
  logic [7:0] div_val;
  int         tick_left;
  logic [7:0] tmr_val;
  logic [1:0] held_sel;

  logic [6:0] cycles_q[$];
  step_res_t  expected_steps[$];

  int  pushed_total;
  int  launched;
  int  accepted_in;
  int  results_seen;
  int  irqs_seen;
  int  cfg_writes;
  int  mismatches;
  int  quiet_cycles;
  logic src_hold;
  int  src_idle_pct;
  int  snk_stall_pct;
  int  hold_req;
  int  hold_ack;
  int  hold_left;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int period_cycles(input logic [1:0] sel);
    case (sel)
      2'd0:    return 1024;
      2'd1:    return 16;
      2'd2:    return 64;
      default: return 256;
    endcase
  endfunction

  function automatic step_res_t step_timer(input logic [6:0] cyc);
    step_res_t r;
    int        c;
    int        t;
    c = int'(cyc);
    r.intr = 1'b0;
    div_left -= c;
    if (div_left <= 0) begin
      div_val  = div_val + 8'd1;
      div_left += 256;
    end
    if (cfg_en) begin
      if (held_sel == cfg_sel) begin
        t = tick_left - c;
        if (t < -32768) t = -32768;
        if (t <= -4) begin
          if (tmr_val == 8'hFF) begin
            tmr_val = cfg_mod;
            r.intr  = 1'b1;
          end else begin
            tmr_val = tmr_val + 8'd1;
          end
          t += period_cycles(held_sel);
        end
        if (t > 32767) t = 32767;
        tick_left = t;
      end else begin
        // select changed: restart the timer on the new period
        held_sel  = cfg_sel;
        tmr_val   = 8'h00;
        tick_left = period_cycles(cfg_sel);
      end
    end
    r.divider = div_val;
    r.timer   = tmr_val;
    return r;
  endfunction

  function automatic logic [6:0] pick_cycles(input bit fast);
    if (fast) return 7'($urandom_range(16, 127));
    case ($urandom_range(0, 9))
      0:       return 7'd0;
      1:       return 7'd127;
      2:       return 7'd64;
      3, 4, 5: return 7'($urandom_range(0, 127));
      default: return 7'($urandom_range(1, 24));
    endcase
  endfunction

  task automatic note_mismatch(input string what, input step_res_t want,
                               input step_res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%t %s: expected div=%02h tmr=%02h irq=%0b got div=%02h tmr=%02h irq=%0b",
               $realtime, what, want.divider, want.timer, want.intr,
               got.divider, got.timer, got.intr);
  endtask

  // Driver: launch the next word once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid          <= 1'b0;
      in_ch.elapsed_cycles <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (cycles_q.size() > 0 && !src_hold &&
          $urandom_range(0, 99) >= src_idle_pct) begin
        in_ch.valid          <= 1'b1;
        in_ch.elapsed_cycles <= cycles_q.pop_front();
        launched++;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus an occasional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = LongHoldCycles;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Monitor: check result words, then predict for the accepted input word
  always @(posedge clk_i) begin
    step_res_t got;
    step_res_t want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got.divider = out_ch.divider_value;
        got.timer   = out_ch.timer_value;
        got.intr    = out_ch.timer_interrupt;
        results_seen++;
        if (got.intr === 1'b1) irqs_seen++;
        if (expected_steps.size() == 0) begin
          note_mismatch("unexpected result word", '0, got);
        end else begin
          want = expected_steps.pop_front();
          if (got.divider !== want.divider || got.timer !== want.timer ||
              got.intr !== want.intr)
            note_mismatch("result word differs", want, got);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_steps.push_back(step_timer(in_ch.elapsed_cycles));
        accepted_in++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("timeout: no word moved for %0d cycles", quiet_cycles);
        $display("divider_and_reloading_timer_core: mismatch");
        $finish;
      end
    end
  end

  task automatic push_cycles(input logic [6:0] c);
    cycles_q.push_back(c);
    pushed_total++;
  endtask

  task automatic wait_idle();
    while (!(accepted_in == pushed_total && expected_steps.size() == 0))
      @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    case (idx)
      REG_TIMER_ENABLE: cfg_en  = data[0];
      REG_CLOCK_SELECT: cfg_sel = data[1:0];
      REG_TIMER_MODULO: cfg_mod = data;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_mode(input int mode);
    case (mode)
      0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      1:       begin src_idle_pct = 88; snk_stall_pct = 0;  end
      2:       begin src_idle_pct = 0;  snk_stall_pct = 88; end
      default: begin src_idle_pct = 13; snk_stall_pct = 13; end
    endcase
  endtask

  // mask bits: enable, select, modulo
  task automatic run_phase(input logic en, input logic [1:0] sel, input logic [7:0] modv,
                           input logic [2:0] mask, input int n, input bit fast,
                           input int mode);
    wait_idle();
    if (mask[0]) cfg_write(REG_TIMER_ENABLE, {7'($urandom), en});
    if (mask[1]) cfg_write(REG_CLOCK_SELECT, {6'($urandom), sel});
    if (mask[2]) cfg_write(REG_TIMER_MODULO, modv);
    set_mode(mode);
    for (int i = 0; i < n; i++) push_cycles(pick_cycles(fast));
  endtask

  initial begin
    logic [7:0] modv;
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = '0;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.elapsed_cycles = '0;
    out_ch.ready         = 1'b0;
    src_hold             = 1'b0;
    src_idle_pct         = 0;
    snk_stall_pct        = 0;
    hold_req             = 0;
    hold_ack             = 0;
    hold_left            = 0;
    pushed_total         = 0;
    launched             = 0;
    accepted_in          = 0;
    results_seen         = 0;
    irqs_seen            = 0;
    cfg_writes           = 0;
    mismatches           = 0;
    quiet_cycles         = 0;
    cfg_en    = 1'b0;
    cfg_sel   = 2'd0;
    cfg_mod   = 8'h00;
    div_left  = 256;
    div_val   = 8'h00;
    tick_left = 0;
    tmr_val   = 8'h00;
    held_sel  = 2'd0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Timer disabled after reset: divider runs alone
    push_cycles(7'd0);
    push_cycles(7'd127);
    push_cycles(7'd1);
    push_cycles(7'd64);
    push_cycles(7'd127);
    push_cycles(7'd127);

    // Enable with extra data bits set; the unused index must change nothing
    wait_idle();
    cfg_write(REG_TIMER_ENABLE, 8'hFF);
    cfg_write(REG_UNUSED, 8'h5A);
    push_cycles(7'd3);
    push_cycles(7'd4);
    push_cycles(7'd127);
    push_cycles(7'd0);

    // Select change while enabled restarts the timer on the short period
    wait_idle();
    cfg_write(REG_CLOCK_SELECT, 8'hFD);
    cfg_write(REG_TIMER_MODULO, 8'hFF);
    push_cycles(7'd5);
    push_cycles(7'd20);
    push_cycles(7'd19);
    push_cycles(7'd127);
    push_cycles(7'd0);

    // Disabled timer holds while the divider keeps going
    wait_idle();
    cfg_write(REG_TIMER_ENABLE, 8'h00);
    push_cycles(7'd127);
    push_cycles(7'd64);

    // Select changed while disabled takes effect on re-enable
    wait_idle();
    cfg_write(REG_CLOCK_SELECT, 8'h03);
    cfg_write(REG_TIMER_ENABLE, 8'h01);
    push_cycles(7'd10);
    push_cycles(7'd127);
    push_cycles(7'd127);
    push_cycles(7'd6);

    // Fast steps on the short period reach overflow, then reload at 0xFF
    run_phase(1'b1, 2'd1, 8'hFF, 3'b111, 320, 1'b1, 0);
    run_phase(1'b1, 2'd1, 8'h00, 3'b100, 100, 1'b0, 1);
    run_phase(1'b0, 2'd2, 8'h5C, 3'b111, 60, 1'b0, 2);
    run_phase(1'b1, 2'd2, 8'h80, 3'b111, 120, 1'b0, 3);
    run_phase(1'b1, 2'd3, 8'hFE, 3'b110, 100, 1'b1, 1);
    run_phase(1'b1, 2'd0, 8'($urandom), 3'b111, 100, 1'b0, 0);

    // Back up the block with a long receiver hold, then drain before resuming
    while (cycles_q.size() > 70) @(posedge clk_i);
    hold_req++;
    while (cycles_q.size() > 30) @(posedge clk_i);
    src_hold = 1'b1;
    do @(posedge clk_i);
    while (!(launched == accepted_in && expected_steps.size() == 0));
    src_hold = 1'b0;

    for (int k = 0; k < 6; k++) begin
      case ($urandom_range(0, 3))
        0:       modv = 8'hFF;
        1:       modv = 8'h00;
        default: modv = 8'($urandom);
      endcase
      run_phase(logic'($urandom_range(0, 4) != 0), 2'($urandom_range(0, 3)), modv,
                3'b111, 100, bit'($urandom_range(0, 1)), k % 4);
    end

    wait_idle();
    repeat (4) @(posedge clk_i);
    $display("covered %0d steps and %0d results with %0d timer interrupts",
             accepted_in, results_seen, irqs_seen);
    $display("%0d register writes across phases, %0d field mismatches",
             cfg_writes, mismatches);
    if (mismatches == 0 && expected_steps.size() == 0) begin
      $display("divider_and_reloading_timer_core: match");
    end else begin
      $display("divider_and_reloading_timer_core: mismatch");
    end
    $finish;
  end

endmodule
